// ===== design/nmrn_pkg.sv =====
// ----------------------------------------------------------------------------
// nmrn_pkg
// Shared types, constants and elaboration-time tables for the nontwist map
// rotation number engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nmrn_pkg;

  // fixed-point format of the fields and the internal 64-bit datapath word
  localparam int FRAC_BITS     = 40;
  localparam int STEP_BITS     = 21;
  localparam int WORD_BITS     = 48;
  localparam int CORD_FRAC     = 60;
  localparam int CORDIC_ROUNDS = 40;
  localparam int K_BITS        = $clog2(CORDIC_ROUNDS);
  localparam int CUT_BITS      = 47;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 64;

  typedef logic signed [63:0]          acc_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [STEP_BITS-1:0]        step_t;

  localparam acc_t  SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam acc_t  ONE       = 64'sd1 <<< FRAC_BITS;
  localparam acc_t  QUARTER   = 64'sd1 <<< (FRAC_BITS - 2);
  localparam step_t MAX_STEPS = step_t'(1) << (STEP_BITS - 1);
  localparam step_t MIN_STEPS = step_t'(2);

  localparam logic [63:0] C_ONE = 64'd1 << CORD_FRAC;

  // register map
  typedef enum logic [1:0] {
    REG_ITER_LIMIT = 2'd0,
    REG_SETTLE_LAG = 2'd1,
    REG_CONV_CUT   = 2'd2,
    REG_POINT_SEL  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    step_t               iteration_limit;
    step_t               settle_lag;
    logic [CUT_BITS-1:0] conv_cutoff;
    logic                point_select;
  } cfg_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_THETA,
    OP_MUL_BS,
    OP_MUL_YY,
    OP_MUL_AW,
    OP_CORDIC_INIT,
    OP_CORDIC_STEP,
    OP_SINE,
    OP_UPD_Y,
    OP_UPD_W,
    OP_UPD_X,
    OP_OMO1,
    OP_DIV_START,
    OP_TRACK,
    OP_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic cordic_last;
    logic first_step;
    logic keep_going;
    logic out_busy;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_THETA,
    ST_THETA_WAIT,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_SINE,
    ST_BS,
    ST_BS_WAIT,
    ST_UPD_Y,
    ST_YY,
    ST_YY_WAIT,
    ST_UPD_W,
    ST_AW,
    ST_AW_WAIT,
    ST_UPD_X,
    ST_OMO1,
    ST_DIV,
    ST_DIV_WAIT,
    ST_TRACK,
    ST_CHECK,
    ST_DONE,
    ST_PUBLISH
  } state_e;

  typedef struct packed {
    word_t omega;
    logic  omega_undefined;
    step_t conv_step;
    word_t max_diff;
    logic  max_diff_valid;
    step_t max_diff_step;
    word_t omega_max;
    step_t omega_max_step;
    word_t omega_min;
    step_t omega_min_step;
  } res_t;

  // long division by shift and subtract, elaboration only
  function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], n[j]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(1/nn) by its series
  function automatic longint atan_recip(input longint nn);
    longint pw, sum, m, t, nn2;
    pw  = longint'(cdiv(C_ONE, nn));
    sum = 0;
    m   = 0;
    nn2 = nn * nn;
    while (pw != 0) begin
      t   = longint'(cdiv(pw, 2 * m + 1));
      sum = m[0] ? sum - t : sum + t;
      pw  = longint'(cdiv(pw, nn2));
      m++;
    end
    return sum;
  endfunction

  // arctan(2^-k) by its series
  function automatic longint atan_pow2(input int k);
    longint pw, sum, m, t;
    int     sh;
    pw  = longint'(C_ONE >> k);
    sum = 0;
    m   = 0;
    sh  = 2 * k;
    while (pw != 0) begin
      t   = longint'(cdiv(pw, 2 * m + 1));
      sum = m[0] ? sum - t : sum + t;
      pw  = (sh < 63) ? (pw >>> sh) : 0;
      m++;
    end
    return sum;
  endfunction

  typedef logic signed [63:0] atn_tab_t [CORDIC_ROUNDS];

  function automatic atn_tab_t build_atn();
    atn_tab_t t;
    longint   qpi;
    qpi  = 4 * atan_recip(5) - atan_recip(239);
    t[0] = qpi;
    for (int k = 1; k < CORDIC_ROUNDS; k++) begin
      t[k] = atan_pow2(k);
    end
    return t;
  endfunction

  localparam atn_tab_t ATN    = build_atn();
  localparam acc_t     TWO_PI = ATN[0] <<< 3;

  // raw cordic gain from a unit vector at zero angle
  function automatic logic [63:0] cordic_gain(input atn_tab_t t);
    longint x, y, z, xs, ys;
    x = longint'(C_ONE);
    y = 0;
    z = 0;
    for (int k = 0; k < CORDIC_ROUNDS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - t[k];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + t[k];
      end
    end
    return 64'(x);
  endfunction

  // floor(2^e / d)
  function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int j = e; j >= 0; j--) begin
      rem = {rem[63:0], (j == e)};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam acc_t KINV = acc_t'(pow2_div(2 * CORD_FRAC, cordic_gain(ATN)));

endpackage

`default_nettype wire

// ===== design/nmrn_in_if.sv =====
// ----------------------------------------------------------------------------
// nmrn_in_if
// Input channel: map parameters with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nmrn_in_if;
  logic           valid;
  logic           ready;
  nmrn_pkg::word_t param_a;
  nmrn_pkg::word_t param_b;

  modport source (output valid, output param_a, output param_b, input ready);
  modport sink   (input valid, input param_a, input param_b, output ready);
endinterface

`default_nettype wire

// ===== design/nmrn_out_if.sv =====
// ----------------------------------------------------------------------------
// nmrn_out_if
// Output channel: rotation number result with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nmrn_out_if;
  logic            valid;
  logic            ready;
  nmrn_pkg::word_t omega;
  logic            omega_undefined;
  nmrn_pkg::step_t conv_step;
  nmrn_pkg::word_t max_diff;
  logic            max_diff_valid;
  nmrn_pkg::step_t max_diff_step;
  nmrn_pkg::word_t omega_max;
  nmrn_pkg::step_t omega_max_step;
  nmrn_pkg::word_t omega_min;
  nmrn_pkg::step_t omega_min_step;

  modport source (
    output valid, output omega, output omega_undefined, output conv_step,
    output max_diff, output max_diff_valid, output max_diff_step,
    output omega_max, output omega_max_step, output omega_min, output omega_min_step,
    input ready
  );
  modport sink (
    input valid, input omega, input omega_undefined, input conv_step,
    input max_diff, input max_diff_valid, input max_diff_step,
    input omega_max, input omega_max_step, input omega_min, input omega_min_step,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/nontwist_map_rotation_number.sv =====
// ----------------------------------------------------------------------------
// nontwist_map_rotation_number
// Rotation number of the standard nontwist map, one orbit per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer (a, b) starts a fresh orbit from x0 = a/2 +/- 0.25,
// y0 = 0 and returns one result transfer once the orbit settles or the
// iteration limit is reached. One map step runs a 40-rotation
// cordic for the sine (one rotation a cycle, plus set-up and quadrant fold),
// four multiplies on a single shared 32x32 multiplier (four partial products
// plus rounding each), three update steps, a radix-2 divider for omega, and
// a track state and a stop-check state. The first step has no division.
// One orbit is in work at a time; the result sits in an output register so
// the next item can be taken while it waits. Configuration is through a
// 64-bit APB-style port, registers at 8-byte spacing; the user must write
// them only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module nontwist_map_rotation_number (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  nmrn_in_if.sink                          in_i,
  nmrn_out_if.source                       out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nmrn_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [nmrn_pkg::DATA_BITS-1:0]   pwdata,
  output logic [nmrn_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);

  nmrn_pkg::cfg_t    cfg_q;
  nmrn_pkg::cmd_e    cmd;
  nmrn_pkg::status_t status;
  nmrn_pkg::res_t    res;
  nmrn_pkg::reg_idx_e reg_idx;

  assign reg_idx = nmrn_pkg::reg_idx_e'(paddr[nmrn_pkg::ADDR_BITS-1:3]);
  assign pready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.iteration_limit <= nmrn_pkg::step_t'(1000);
      cfg_q.settle_lag      <= nmrn_pkg::step_t'(100);
      cfg_q.conv_cutoff     <= nmrn_pkg::CUT_BITS'(1099512);
      cfg_q.point_select    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        nmrn_pkg::REG_ITER_LIMIT: cfg_q.iteration_limit <= pwdata[nmrn_pkg::STEP_BITS-1:0];
        nmrn_pkg::REG_SETTLE_LAG: cfg_q.settle_lag      <= pwdata[nmrn_pkg::STEP_BITS-1:0];
        nmrn_pkg::REG_CONV_CUT:   cfg_q.conv_cutoff     <= pwdata[nmrn_pkg::CUT_BITS-1:0];
        nmrn_pkg::REG_POINT_SEL:  cfg_q.point_select    <= pwdata[0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      nmrn_pkg::REG_ITER_LIMIT: prdata = nmrn_pkg::DATA_BITS'(cfg_q.iteration_limit);
      nmrn_pkg::REG_SETTLE_LAG: prdata = nmrn_pkg::DATA_BITS'(cfg_q.settle_lag);
      nmrn_pkg::REG_CONV_CUT:   prdata = nmrn_pkg::DATA_BITS'(cfg_q.conv_cutoff);
      nmrn_pkg::REG_POINT_SEL:  prdata = nmrn_pkg::DATA_BITS'(cfg_q.point_select);
    endcase
  end

  nmrn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nmrn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg_q),
    .param_a_i   (in_i.param_a),
    .param_b_i   (in_i.param_b),
    .res_ready_i (out_o.ready),
    .res_valid_o (out_o.valid),
    .res_o       (res)
  );

  // result fields onto the output channel
  assign out_o.omega           = res.omega;
  assign out_o.omega_undefined = res.omega_undefined;
  assign out_o.conv_step       = res.conv_step;
  assign out_o.max_diff        = res.max_diff;
  assign out_o.max_diff_valid  = res.max_diff_valid;
  assign out_o.max_diff_step   = res.max_diff_step;
  assign out_o.omega_max       = res.omega_max;
  assign out_o.omega_max_step  = res.omega_max_step;
  assign out_o.omega_min       = res.omega_min;
  assign out_o.omega_min_step  = res.omega_min_step;

endmodule

`default_nettype wire

// ===== design/nmrn_mul.sv =====
// ----------------------------------------------------------------------------
// nmrn_mul
// Sign-magnitude fixed-point multiplier: 64x64 magnitudes through one
// 32x32 multiplier over four partial products, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrn_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                neg_i,
  input  logic [63:0]         ua_i,
  input  logic [63:0]         ub_i,
  output logic                done_o,
  output nmrn_pkg::acc_t      res_o
);

  logic [63:0]    ua_q, ub_q;
  logic           neg_q;
  logic           busy_q, done_q;
  logic [2:0]     cnt_q;
  logic [63:0]    prod_q;
  logic [1:0]     psh_q;
  logic [127:0]   acc_q;
  nmrn_pkg::acc_t res_q;

  logic [31:0]    ah, bh;
  logic [127:0]   addend, rnd;
  logic           over;
  logic [63:0]    mag, magc;

  // partial product operands
  assign ah = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign bh = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];

  assign addend = {64'd0, prod_q} << {psh_q, 5'd0};

  // rounding, overflow and magnitude clamp
  always_comb begin
    rnd  = acc_q + (128'd1 << (nmrn_pkg::FRAC_BITS - 1));
    over = |rnd[127:64+nmrn_pkg::FRAC_BITS];
    mag  = over ? '1 : rnd[63+nmrn_pkg::FRAC_BITS:nmrn_pkg::FRAC_BITS];
    magc = mag[63] ? 64'(nmrn_pkg::SAT_MAX) : mag;
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands, products and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= ua_i;
      ub_q  <= ub_i;
      neg_q <= neg_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q <= 3'd3) begin
        prod_q <= ah * bh;
        psh_q  <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + addend;
      end
      if (cnt_q == 3'd5) begin
        res_q <= neg_q ? -nmrn_pkg::acc_t'(magc) : nmrn_pkg::acc_t'(magc);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== design/nmrn_div.sv =====
// ----------------------------------------------------------------------------
// nmrn_div
// Radix-2 restoring divider: 64-bit dividend by a step count, one quotient
// bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrn_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [63:0]     n_i,
  input  nmrn_pkg::step_t d_i,
  output logic            done_o,
  output logic [63:0]     q_o
);

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [63:0]     n_q;
  nmrn_pkg::step_t rem_q, d_q;

  logic [nmrn_pkg::STEP_BITS:0] trial;
  logic                         fits;

  // one restoring step
  assign trial = {rem_q, n_q[63]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out while quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      d_q   <= d_i;
      rem_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[62:0], fits};
      rem_q <= fits ? nmrn_pkg::step_t'(trial - {1'b0, d_q})
                    : trial[nmrn_pkg::STEP_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = n_q;

endmodule

`default_nettype wire

// ===== design/nmrn_dp.sv =====
// ----------------------------------------------------------------------------
// nmrn_dp
// Datapath: orbit state, cordic sine, shared multiplier and divider,
// omega tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrn_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nmrn_pkg::cmd_e    cmd_i,
  output nmrn_pkg::status_t status_o,
  input  nmrn_pkg::cfg_t    cfg_i,
  input  nmrn_pkg::word_t   param_a_i,
  input  nmrn_pkg::word_t   param_b_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output nmrn_pkg::res_t    res_o
);

  localparam int W  = nmrn_pkg::WORD_BITS;
  localparam int FB = nmrn_pkg::FRAC_BITS;
  localparam int SB = nmrn_pkg::STEP_BITS;
  localparam int RS = nmrn_pkg::CORD_FRAC - nmrn_pkg::FRAC_BITS;

  localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam nmrn_pkg::word_t    W_MAX  = {1'b0, {(W-1){1'b1}}};
  localparam nmrn_pkg::word_t    W_MIN  = {1'b1, {(W-1){1'b0}}};

  // saturating helpers
  function automatic nmrn_pkg::acc_t sat65(input logic signed [64:0] s);
    if (s > SMAX65) return nmrn_pkg::SAT_MAX;
    if (s < -SMAX65) return -nmrn_pkg::SAT_MAX;
    return nmrn_pkg::acc_t'(s[63:0]);
  endfunction

  function automatic nmrn_pkg::acc_t sat_add(input nmrn_pkg::acc_t p, input nmrn_pkg::acc_t q);
    return sat65({p[63], p} + {q[63], q});
  endfunction

  function automatic nmrn_pkg::acc_t sat_sub(input nmrn_pkg::acc_t p, input nmrn_pkg::acc_t q);
    return sat65({p[63], p} - {q[63], q});
  endfunction

  function automatic nmrn_pkg::word_t sat_w(input nmrn_pkg::acc_t v);
    if (v > 64'(W_MAX)) return W_MAX;
    if (v < 64'(W_MIN)) return W_MIN;
    return v[W-1:0];
  endfunction

  function automatic nmrn_pkg::word_t sat_w49(input logic signed [W:0] v);
    if (v > $signed({W_MAX[W-1], W_MAX})) return W_MAX;
    if (v < $signed({W_MIN[W-1], W_MIN})) return W_MIN;
    return v[W-1:0];
  endfunction

  function automatic logic [63:0] mag(input nmrn_pkg::acc_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // orbit and unit registers
  nmrn_pkg::acc_t  a_q, b_q, x0_q, x_q, y_q, w_q, sine_q, cx_q, cy_q, cz_q;
  logic [1:0]      quad_q;
  logic [nmrn_pkg::K_BITS-1:0] k_q;
  logic            first_q, in_band_q, valid_q, dneg_q;
  nmrn_pkg::word_t omo_q, om_q, omax_q, omin_q;
  logic signed [W:0] md_q;
  nmrn_pkg::step_t i_q, ncut_q, mds_q, nmax_q, nmin_q;
  logic            out_valid_q;
  nmrn_pkg::res_t  res_q;

  // effective limit
  nmrn_pkg::step_t lim_c;
  always_comb begin
    priority if (cfg_i.iteration_limit < nmrn_pkg::MIN_STEPS) lim_c = nmrn_pkg::MIN_STEPS;
    else if (cfg_i.iteration_limit > nmrn_pkg::MAX_STEPS) lim_c = nmrn_pkg::MAX_STEPS;
    else lim_c = cfg_i.iteration_limit;
  end

  // start point
  nmrn_pkg::acc_t a_ext, b_ext, x0_c;
  assign a_ext = {{(64-W){param_a_i[W-1]}}, param_a_i};
  assign b_ext = {{(64-W){param_b_i[W-1]}}, param_b_i};
  assign x0_c  = (a_ext >>> 1) + (cfg_i.point_select ? -nmrn_pkg::QUARTER : nmrn_pkg::QUARTER);

  // shared multiplier
  logic           mul_start, mul_neg, mul_done;
  logic [63:0]    mul_ua, mul_ub;
  nmrn_pkg::acc_t mul_res;

  always_comb begin
    mul_start = 1'b0;
    mul_neg   = 1'b0;
    mul_ua    = '0;
    mul_ub    = '0;
    unique case (cmd_i)
      nmrn_pkg::OP_MUL_THETA: begin
        mul_start = 1'b1;
        mul_ua    = {{(66-FB){1'b0}}, x_q[FB-3:0]};
        mul_ub    = 64'(nmrn_pkg::TWO_PI);
      end
      nmrn_pkg::OP_MUL_BS: begin
        mul_start = 1'b1;
        mul_neg   = b_q[63] != sine_q[63];
        mul_ua    = mag(b_q);
        mul_ub    = mag(sine_q);
      end
      nmrn_pkg::OP_MUL_YY: begin
        mul_start = 1'b1;
        mul_ua    = mag(y_q);
        mul_ub    = mag(y_q);
      end
      nmrn_pkg::OP_MUL_AW: begin
        mul_start = 1'b1;
        mul_neg   = a_q[63] != w_q[63];
        mul_ua    = mag(a_q);
        mul_ub    = mag(w_q);
      end
      default: ;
    endcase
  end

  nmrn_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .neg_i   (mul_neg),
    .ua_i    (mul_ua),
    .ub_i    (mul_ub),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // divider for omega
  nmrn_pkg::acc_t dist_c;
  logic [63:0]    div_n, div_q;
  logic           div_start, div_done;

  assign dist_c    = sat_sub(x_q, x0_q);
  assign div_n     = mag(dist_c) + {{(64-SB+1){1'b0}}, i_q[SB-1:1]};
  assign div_start = cmd_i == nmrn_pkg::OP_DIV_START;

  nmrn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (i_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // cordic rotation
  nmrn_pkg::acc_t xs, ys;
  assign xs = cx_q >>> k_q;
  assign ys = cy_q >>> k_q;

  // sine from quadrant and rounding back to the field format
  nmrn_pkg::acc_t sv, sine_c;
  logic [63:0]    sm;
  always_comb begin
    unique case (quad_q)
      2'd0: sv = cy_q;
      2'd1: sv = cx_q;
      2'd2: sv = -cy_q;
      2'd3: sv = -cx_q;
    endcase
    sm     = (mag(sv) + (64'd1 << (RS - 1))) >> RS;
    sine_c = sv[63] ? -nmrn_pkg::acc_t'(sm) : nmrn_pkg::acc_t'(sm);
  end

  // omega and band tracking
  nmrn_pkg::word_t   om_c;
  logic signed [W:0] diff_c;
  logic [W:0]        ad_c, amd_c, cut_c;
  always_comb begin
    if (!dneg_q) om_c = (div_q > 64'(W_MAX)) ? W_MAX : div_q[W-1:0];
    else om_c = (div_q > (64'd1 << (W - 1))) ? W_MIN : -nmrn_pkg::word_t'(div_q[W-1:0]);
    diff_c = {om_c[W-1], om_c} - {omo_q[W-1], omo_q};
    ad_c   = diff_c[W] ? (W+1)'(-diff_c) : (W+1)'(diff_c);
    amd_c  = md_q[W] ? (W+1)'(-md_q) : (W+1)'(md_q);
    cut_c  = (W+1)'(cfg_i.conv_cutoff);
  end

  // stop condition
  logic [SB:0] lag_c;
  logic        lim_ok, going_c;
  assign lag_c   = {1'b0, cfg_i.settle_lag};
  assign lim_ok  = i_q <= lim_c;
  assign going_c = ({1'b0, i_q} <= {1'b0, ncut_q} + lag_c)
                || ({1'b0, i_q} <= {1'b0, nmax_q} + lag_c)
                || ({1'b0, i_q} <= {1'b0, nmin_q} + lag_c);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == nmrn_pkg::OP_CORDIC_INIT) k_q <= '0;
      else if (cmd_i == nmrn_pkg::OP_CORDIC_STEP) k_q <= k_q + 1'b1;
      if (cmd_i == nmrn_pkg::OP_PUBLISH) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      nmrn_pkg::OP_LOAD: begin
        a_q       <= a_ext;
        b_q       <= b_ext;
        x0_q      <= x0_c;
        x_q       <= x0_c;
        y_q       <= '0;
        first_q   <= 1'b1;
        i_q       <= nmrn_pkg::MIN_STEPS;
        ncut_q    <= lim_c + 1'b1;
        mds_q     <= lim_c + 1'b1;
        nmax_q    <= '0;
        nmin_q    <= '0;
        md_q      <= '0;
        valid_q   <= 1'b0;
        in_band_q <= 1'b0;
        om_q      <= '0;
        omax_q    <= '0;
        omin_q    <= '0;
      end
      nmrn_pkg::OP_MUL_THETA: quad_q <= x_q[FB-1:FB-2];
      nmrn_pkg::OP_CORDIC_INIT: begin
        cx_q <= nmrn_pkg::KINV;
        cy_q <= '0;
        cz_q <= mul_res;
      end
      nmrn_pkg::OP_CORDIC_STEP: begin
        if (!cz_q[63]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - nmrn_pkg::ATN[k_q];
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + nmrn_pkg::ATN[k_q];
        end
      end
      nmrn_pkg::OP_SINE:  sine_q <= sine_c;
      nmrn_pkg::OP_UPD_Y: y_q <= sat_sub(y_q, mul_res);
      nmrn_pkg::OP_UPD_W: w_q <= sat_sub(nmrn_pkg::ONE, mul_res);
      nmrn_pkg::OP_UPD_X: x_q <= sat_add(x_q, mul_res);
      nmrn_pkg::OP_OMO1: begin
        omo_q   <= sat_w(dist_c);
        first_q <= 1'b0;
      end
      nmrn_pkg::OP_DIV_START: dneg_q <= dist_c[63];
      nmrn_pkg::OP_TRACK: begin
        om_q  <= om_c;
        omo_q <= om_c;
        i_q   <= i_q + 1'b1;
        if (i_q == nmrn_pkg::MIN_STEPS || om_c > omax_q) begin
          omax_q <= om_c;
          nmax_q <= i_q;
        end
        if (i_q == nmrn_pkg::MIN_STEPS || om_c < omin_q) begin
          omin_q <= om_c;
          nmin_q <= i_q;
        end
        // band entry and exit
        if (in_band_q) begin
          if (ad_c >= cut_c) begin
            in_band_q <= 1'b0;
            ncut_q    <= lim_c + 1'b1;
          end
          if (ad_c > amd_c) begin
            md_q  <= diff_c;
            mds_q <= i_q;
          end
        end else if (ad_c < cut_c) begin
          in_band_q <= 1'b1;
          valid_q   <= 1'b1;
          ncut_q    <= i_q;
          md_q      <= diff_c;
          mds_q     <= i_q;
        end
      end
      nmrn_pkg::OP_PUBLISH: begin
        res_q.omega           <= (!lim_ok && going_c) ? '0 : om_q;
        res_q.omega_undefined <= !lim_ok && going_c;
        res_q.conv_step       <= ncut_q;
        res_q.max_diff        <= valid_q ? sat_w49(md_q) : '0;
        res_q.max_diff_valid  <= valid_q;
        res_q.max_diff_step   <= mds_q;
        res_q.omega_max       <= omax_q;
        res_q.omega_max_step  <= nmax_q;
        res_q.omega_min       <= omin_q;
        res_q.omega_min_step  <= nmin_q;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    status_o.mul_done    = mul_done;
    status_o.div_done    = div_done;
    status_o.cordic_last = k_q == nmrn_pkg::K_BITS'(nmrn_pkg::CORDIC_ROUNDS - 1);
    status_o.first_step  = first_q;
    status_o.keep_going  = lim_ok && going_c;
    status_o.out_busy    = out_valid_q;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/nmrn_ctrl.sv =====
// ----------------------------------------------------------------------------
// nmrn_ctrl
// Controller: sequences each map step through the shared units and decides
// when an orbit has settled.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nmrn_pkg::status_t status_i,
  output nmrn_pkg::cmd_e    cmd_o
);

  nmrn_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nmrn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nmrn_pkg::ST_IDLE:        if (in_valid_i) state_d = nmrn_pkg::ST_THETA;
      nmrn_pkg::ST_THETA:       state_d = nmrn_pkg::ST_THETA_WAIT;
      nmrn_pkg::ST_THETA_WAIT:  if (status_i.mul_done) state_d = nmrn_pkg::ST_CORDIC_INIT;
      nmrn_pkg::ST_CORDIC_INIT: state_d = nmrn_pkg::ST_CORDIC;
      nmrn_pkg::ST_CORDIC:      if (status_i.cordic_last) state_d = nmrn_pkg::ST_SINE;
      nmrn_pkg::ST_SINE:        state_d = nmrn_pkg::ST_BS;
      nmrn_pkg::ST_BS:          state_d = nmrn_pkg::ST_BS_WAIT;
      nmrn_pkg::ST_BS_WAIT:     if (status_i.mul_done) state_d = nmrn_pkg::ST_UPD_Y;
      nmrn_pkg::ST_UPD_Y:       state_d = nmrn_pkg::ST_YY;
      nmrn_pkg::ST_YY:          state_d = nmrn_pkg::ST_YY_WAIT;
      nmrn_pkg::ST_YY_WAIT:     if (status_i.mul_done) state_d = nmrn_pkg::ST_UPD_W;
      nmrn_pkg::ST_UPD_W:       state_d = nmrn_pkg::ST_AW;
      nmrn_pkg::ST_AW:          state_d = nmrn_pkg::ST_AW_WAIT;
      nmrn_pkg::ST_AW_WAIT:     if (status_i.mul_done) state_d = nmrn_pkg::ST_UPD_X;
      nmrn_pkg::ST_UPD_X: begin
        state_d = status_i.first_step ? nmrn_pkg::ST_OMO1 : nmrn_pkg::ST_DIV;
      end
      nmrn_pkg::ST_OMO1:        state_d = nmrn_pkg::ST_THETA;
      nmrn_pkg::ST_DIV:         state_d = nmrn_pkg::ST_DIV_WAIT;
      nmrn_pkg::ST_DIV_WAIT:    if (status_i.div_done) state_d = nmrn_pkg::ST_TRACK;
      nmrn_pkg::ST_TRACK:       state_d = nmrn_pkg::ST_CHECK;
      nmrn_pkg::ST_CHECK: begin
        state_d = status_i.keep_going ? nmrn_pkg::ST_THETA : nmrn_pkg::ST_DONE;
      end
      nmrn_pkg::ST_DONE:        if (!status_i.out_busy) state_d = nmrn_pkg::ST_PUBLISH;
      nmrn_pkg::ST_PUBLISH:     state_d = nmrn_pkg::ST_IDLE;
      default:                  state_d = nmrn_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = nmrn_pkg::OP_NONE;
    unique case (state_q)
      nmrn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o      = nmrn_pkg::OP_LOAD;
      end
      nmrn_pkg::ST_THETA:       cmd_o = nmrn_pkg::OP_MUL_THETA;
      nmrn_pkg::ST_CORDIC_INIT: cmd_o = nmrn_pkg::OP_CORDIC_INIT;
      nmrn_pkg::ST_CORDIC:      cmd_o = nmrn_pkg::OP_CORDIC_STEP;
      nmrn_pkg::ST_SINE:        cmd_o = nmrn_pkg::OP_SINE;
      nmrn_pkg::ST_BS:          cmd_o = nmrn_pkg::OP_MUL_BS;
      nmrn_pkg::ST_UPD_Y:       cmd_o = nmrn_pkg::OP_UPD_Y;
      nmrn_pkg::ST_YY:          cmd_o = nmrn_pkg::OP_MUL_YY;
      nmrn_pkg::ST_UPD_W:       cmd_o = nmrn_pkg::OP_UPD_W;
      nmrn_pkg::ST_AW:          cmd_o = nmrn_pkg::OP_MUL_AW;
      nmrn_pkg::ST_UPD_X:       cmd_o = nmrn_pkg::OP_UPD_X;
      nmrn_pkg::ST_OMO1:        cmd_o = nmrn_pkg::OP_OMO1;
      nmrn_pkg::ST_DIV:         cmd_o = nmrn_pkg::OP_DIV_START;
      nmrn_pkg::ST_TRACK:       cmd_o = nmrn_pkg::OP_TRACK;
      nmrn_pkg::ST_PUBLISH:     cmd_o = nmrn_pkg::OP_PUBLISH;
      default:                  cmd_o = nmrn_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== test/nmrn_checker.sv =====
// ----------------------------------------------------------------------------
// nmrn_checker
// Watches the configuration port and both channels of the rotation number
// engine. It works out each orbit bit for bit when the parameters are taken,
// and compares every result transfer with the oldest orbit still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrn_checker
  import nmrn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  nmrn_in_if                   in_mon_i,
  nmrn_out_if                  out_mon_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [ADDR_BITS-1:0] paddr_i,
  input  logic [DATA_BITS-1:0] pwdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   results_o
);

  localparam longint      C_UNIT = 64'sd1 <<< CORD_FRAC;
  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint      W_HI = (64'sd1 <<< (WORD_BITS - 1)) - 1;

  longint atan_step [CORDIC_ROUNDS];
  longint turn_rad;
  longint gain_inv;
  cfg_t   cfg;
  res_t   orbit_q [$];

  // ------------------------------------------------------------------
  // fixed-point helpers
  // ------------------------------------------------------------------
  function automatic logic [63:0] mag_of(longint v);
    logic [63:0] r;
    r = v;
    return (v < 0) ? (~r + 64'd1) : r;
  endfunction

  function automatic longint signed_of(bit neg, logic [63:0] m);
    if (m > MAG_MAX) m = MAG_MAX;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint add_sat(longint p, longint q);
    logic signed [64:0] s;
    s = 65'(p) + 65'(q);
    if (q > 0 && s > 65'(SAT_MAX)) return SAT_MAX;
    if (q < 0 && s < -65'(SAT_MAX)) return -SAT_MAX;
    return longint'(s[63:0]);
  endfunction

  function automatic longint sub_sat(longint p, longint q);
    if (q == 64'sh8000_0000_0000_0000) q = -SAT_MAX;
    return add_sat(p, -q);
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > W_HI) return W_HI;
    if (v < -W_HI - 1) return -W_HI - 1;
    return v;
  endfunction

  // unsigned product, rounded shift, all ones when it overflows
  function automatic logic [63:0] mul_round(logic [63:0] u, logic [63:0] v, int sh);
    logic [127:0] p;
    p = {64'd0, u} * {64'd0, v};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic longint fx_mul(longint p, longint q);
    return signed_of((p < 0) != (q < 0), mul_round(mag_of(p), mag_of(q), FRAC_BITS));
  endfunction

  function automatic longint shr_round(longint v, int sh);
    return signed_of(v < 0, (mag_of(v) + (64'd1 << (sh - 1))) >> sh);
  endfunction

  // ------------------------------------------------------------------
  // sine tables
  // ------------------------------------------------------------------
  function automatic longint arctan_inv(longint nn);
    longint pw, sum, m, t;
    pw  = C_UNIT / nn;
    sum = 0;
    m   = 0;
    while (pw != 0) begin
      t   = pw / (2 * m + 1);
      sum = m[0] ? sum - t : sum + t;
      pw  = pw / (nn * nn);
      m++;
    end
    return sum;
  endfunction

  function automatic longint arctan_shift(int k);
    longint pw, sum, m, t;
    pw  = C_UNIT >>> k;
    sum = 0;
    m   = 0;
    while (pw != 0) begin
      t   = pw / (2 * m + 1);
      sum = m[0] ? sum - t : sum + t;
      pw  = (2 * k < 63) ? (pw >>> (2 * k)) : 0;
      m++;
    end
    return sum;
  endfunction

  function automatic void rotate(longint x, longint z, output longint cx, output longint sy);
    longint y, xs, ys;
    y = 0;
    for (int k = 0; k < CORDIC_ROUNDS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[k];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[k];
      end
    end
    cx = x;
    sy = y;
  endfunction

  initial begin
    longint qpi, raw, unused;
    logic [64:0] rem;
    logic [63:0] quo;
    qpi = 4 * arctan_inv(5) - arctan_inv(239);
    atan_step[0] = qpi;
    for (int k = 1; k < CORDIC_ROUNDS; k++) atan_step[k] = arctan_shift(k);
    turn_rad = 8 * qpi;
    rotate(C_UNIT, 0, raw, unused);
    // floor of 2^120 over the raw gain
    rem = '0;
    quo = '0;
    for (int j = 2 * CORD_FRAC; j >= 0; j--) begin
      rem = {rem[63:0], (j == 2 * CORD_FRAC)};
      quo = {quo[62:0], 1'b0};
      if (rem >= {1'b0, raw}) begin
        rem    = rem - {1'b0, raw};
        quo[0] = 1'b1;
      end
    end
    gain_inv = longint'(quo);
  end

  // sin(2 pi x) from the fractional phase
  function automatic longint sin_turn(longint x);
    logic [63:0] xb;
    longint theta, c, s, v;
    xb    = x;
    theta = longint'(mul_round({26'd0, xb[FRAC_BITS-3:0]}, turn_rad, FRAC_BITS));
    rotate(gain_inv, theta, c, s);
    case (xb[FRAC_BITS-1:FRAC_BITS-2])
      2'd0:    v = s;
      2'd1:    v = c;
      2'd2:    v = -s;
      default: v = -c;
    endcase
    return shr_round(v, CORD_FRAC - FRAC_BITS);
  endfunction

  function automatic void map_iter(inout longint x, inout longint y, input longint a,
                                   input longint b);
    y = sub_sat(y, fx_mul(b, sin_turn(x)));
    x = add_sat(x, fx_mul(a, sub_sat(ONE, fx_mul(y, y))));
  endfunction

  // ------------------------------------------------------------------
  // one orbit, from the parameters to the result transfer
  // ------------------------------------------------------------------
  function automatic res_t orbit(word_t pa, word_t pb, cfg_t c);
    longint a, b, x0, x, y, om, prev, md, omax, omin, diff, dx;
    logic [63:0] lim, lag, i, ncut, mds, nmax, nmin, ad;
    bit in_band, seen, going, undef;
    res_t r;
    lim = c.iteration_limit;
    if (lim < 2) lim = 2;
    if (lim > 64'(MAX_STEPS)) lim = 64'(MAX_STEPS);
    lag  = c.settle_lag;
    ncut = lim + 1;
    mds  = lim + 1;
    nmax = 0;
    nmin = 0;
    md   = 0;
    omax = 0;
    omin = 0;
    om   = 0;
    in_band = 0;
    seen    = 0;
    a  = longint'(pa);
    b  = longint'(pb);
    x0 = (a >>> 1) + (c.point_select ? -QUARTER : QUARTER);
    x  = x0;
    y  = 0;
    i  = 2;
    map_iter(x, y, a, b);
    prev = clamp_word(sub_sat(x, x0));
    do begin
      map_iter(x, y, a, b);
      dx = sub_sat(x, x0);
      om = clamp_word(signed_of(dx < 0, (mag_of(dx) + i / 2) / i));
      if (i == 2 || om > omax) begin omax = om; nmax = i; end
      if (i == 2 || om < omin) begin omin = om; nmin = i; end
      diff = om - prev;
      ad   = mag_of(diff);
      if (in_band) begin
        if (ad >= 64'(c.conv_cutoff)) begin
          in_band = 0;
          ncut    = lim + 1;
        end
        if (ad > mag_of(md)) begin
          md  = diff;
          mds = i;
        end
      end else if (ad < 64'(c.conv_cutoff)) begin
        in_band = 1;
        seen    = 1;
        ncut    = i;
        md      = diff;
        mds     = i;
      end
      prev  = om;
      i++;
      going = (i <= ncut + lag) || (i <= nmax + lag) || (i <= nmin + lag);
    end while (i <= lim && going);
    undef = (i > lim) && going;

    r.omega           = undef ? '0 : word_t'(om);
    r.omega_undefined = undef;
    r.conv_step       = step_t'(ncut);
    r.max_diff        = seen ? word_t'(clamp_word(md)) : '0;
    r.max_diff_valid  = seen;
    r.max_diff_step   = step_t'(mds);
    r.omega_max       = word_t'(omax);
    r.omega_max_step  = step_t'(nmax);
    r.omega_min       = word_t'(omin);
    r.omega_min_step  = step_t'(nmin);
    return r;
  endfunction

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    return 1;
  endfunction

  // ------------------------------------------------------------------
  // monitor: register writes, parameter and result transfers
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    int   bad;
    if (!rst_ni) begin
      cfg.iteration_limit <= step_t'(1000);
      cfg.settle_lag      <= step_t'(100);
      cfg.conv_cutoff     <= 47'd1099512;
      cfg.point_select    <= 1'b0;
      orbit_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:3]))
          REG_ITER_LIMIT: cfg.iteration_limit <= pwdata_i[STEP_BITS-1:0];
          REG_SETTLE_LAG: cfg.settle_lag      <= pwdata_i[STEP_BITS-1:0];
          REG_CONV_CUT:   cfg.conv_cutoff     <= pwdata_i[CUT_BITS-1:0];
          REG_POINT_SEL:  cfg.point_select    <= pwdata_i[0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready)
        orbit_q.push_back(orbit(in_mon_i.param_a, in_mon_i.param_b, cfg));
      if (out_mon_i.valid && out_mon_i.ready) begin
        results_o <= results_o + 1;
        got.omega           = out_mon_i.omega;
        got.omega_undefined = out_mon_i.omega_undefined;
        got.conv_step       = out_mon_i.conv_step;
        got.max_diff        = out_mon_i.max_diff;
        got.max_diff_valid  = out_mon_i.max_diff_valid;
        got.max_diff_step   = out_mon_i.max_diff_step;
        got.omega_max       = out_mon_i.omega_max;
        got.omega_max_step  = out_mon_i.omega_max_step;
        got.omega_min       = out_mon_i.omega_min;
        got.omega_min_step  = out_mon_i.omega_min_step;
        if (orbit_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, omega %0h", $time,
                   got.omega);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = orbit_q.pop_front();
          bad  = field_diff("omega", 64'(want.omega), 64'(got.omega))
               + field_diff("omega_undefined", 64'(want.omega_undefined),
                            64'(got.omega_undefined))
               + field_diff("conv_step", 64'(want.conv_step), 64'(got.conv_step))
               + field_diff("max_diff", 64'(want.max_diff), 64'(got.max_diff))
               + field_diff("max_diff_valid", 64'(want.max_diff_valid),
                            64'(got.max_diff_valid))
               + field_diff("max_diff_step", 64'(want.max_diff_step),
                            64'(got.max_diff_step))
               + field_diff("omega_max", 64'(want.omega_max), 64'(got.omega_max))
               + field_diff("omega_max_step", 64'(want.omega_max_step),
                            64'(got.omega_max_step))
               + field_diff("omega_min", 64'(want.omega_min), 64'(got.omega_min))
               + field_diff("omega_min_step", 64'(want.omega_min_step),
                            64'(got.omega_min_step));
          fail_count_o <= fail_count_o + bad;
        end
      end
      pending_o <= orbit_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the rotation number engine: register settings, directed
// parameter pairs at the extremes and random orbits with random idling on
// both channels, then the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import nmrn_pkg::*;

  localparam int     TIMEOUT = 6_000_000;
  localparam word_t  P_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam word_t  P_MIN = 48'sh8000_0000_0000;
  localparam longint FONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0] CUT_MAX = 64'h0000_7FFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  int  fails, pending, results;
  int  cycles = 0;
  int  items = 0;
  int  writes = 0;
  bit  tx_steady = 0, rx_steady = 0, hold_go = 0, hold_done = 0;
  int  hold_left = 0;

  nmrn_in_if  in_ch ();
  nmrn_out_if out_ch ();

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.param_a = '0;
    in_ch.param_b = '0;
    out_ch.ready  = 1'b0;
  end

  nontwist_map_rotation_number dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nmrn_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fails),
    .pending_o    (pending),
    .results_o    (results)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_steady || ($urandom_range(0, 99) >= 35);
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx) << 3;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    writes++;
  endtask

  task automatic set_all(logic [63:0] lim, logic [63:0] lag, logic [63:0] cut,
                         logic [63:0] sel);
    reg_write(REG_ITER_LIMIT, lim);
    reg_write(REG_SETTLE_LAG, lag);
    reg_write(REG_CONV_CUT, cut);
    reg_write(REG_POINT_SEL, sel);
  endtask

  // one parameter transfer, with random gaps ahead of it
  task automatic send(word_t a, word_t b);
    while (!tx_steady && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.param_a <= a;
    in_ch.param_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic word_t fx(real v);
    return word_t'(longint'(v * real'(FONE)));
  endfunction

  // mostly moderate magnitudes, sometimes any 48-bit pattern
  function automatic word_t rnd_param();
    if ($urandom_range(0, 99) < 30) return word_t'({$urandom, $urandom});
    return word_t'((longint'(int'($urandom)) <<< 10) | longint'($urandom_range(0, 1023)));
  endfunction

  initial begin
    logic [63:0] cut;
    int phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: a still orbit and a typical one
    send(fx(0.0), fx(0.0));
    send(fx(0.8), fx(0.6));
    drain();

    // limit below two, lower start point, widest band; upper bits dropped
    set_all(64'hABC0_0000_0000_0000, 64'hFFFF_FFFF_FFE0_0000,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(fx(0.0), fx(0.0));
    send(P_MAX, P_MAX);
    send(P_MIN, P_MIN);
    send(P_MAX, P_MIN);
    send(P_MIN, P_MAX);
    send(fx(-0.5), fx(1.0));
    send(48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA);
    drain();

    // limit of one, a lag of 2^20, empty band: always undefined
    set_all(64'd1, 64'd1048576, 64'd0, 64'd0);
    send(fx(0.8), fx(0.6));
    send(P_MAX, 48'sd0);
    send(48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555);
    drain();

    // limit above range, no lag, twist-free orbits settle at once
    set_all(64'h1F_FFFF, 64'd0, CUT_MAX, 64'd0);
    send(fx(0.0), fx(0.0));
    send(P_MAX, 48'sd0);
    send(P_MIN, 48'sd0);
    send(fx(0.3), 48'sd0);
    send(fx(-1.7), 48'sd0);
    drain();

    // random settings, with a long result hold-off in the first phase
    phase = 0;
    while (items < 100) begin
      case ($urandom_range(0, 3))
        0:       cut = 64'd0;
        1:       cut = CUT_MAX;
        default: cut = ({$urandom, $urandom} & CUT_MAX) >> $urandom_range(4, 30);
      endcase
      if (phase == 0) begin
        set_all(64'd3, 64'd0, cut, 64'($urandom_range(0, 1)));
        tx_steady = 1;
        hold_go   = 1;
      end else begin
        set_all(64'($urandom_range(2, 40)), 64'($urandom_range(0, 6)), cut,
                64'($urandom_range(0, 1)));
        tx_steady = (phase == 3);
        rx_steady = (phase == 3);
      end
      repeat (12) send(rnd_param(), rnd_param());
      drain();
      phase++;
    end

    // let anything stray come out
    repeat (500) @(posedge clk_i);
    $display("ran %0d orbits over %0d register writes, %0d results checked", items,
             writes, results);
    $display("covered limit and lag extremes, empty and full bands, both start points");
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
